// ===== rtl/indexed_work_list_store_core_macros.svh =====
// Assertion macros used by the work-list store port checker
`ifndef INDEXED_WORK_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_WORK_LIST_STORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define IWLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define IWLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iwls_pkg.sv =====
// Types and codes shared by the work-list store modules
package iwls_pkg;

    // Operation codes carried on func
    typedef enum logic [2:0] {
        FUNC_INSERT     = 3'd0,
        FUNC_POP_TOP    = 3'd1,
        FUNC_POP_FRONT  = 3'd2,
        FUNC_READ       = 3'd3,
        FUNC_SET_STATE  = 3'd4,
        FUNC_STATUS     = 3'd5
    } func_t;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_INDEX = 2'd3
    } err_t;

    // Field widths of the ports
    localparam int unsigned IDX_IN_W  = 12;
    localparam int unsigned IDX_OUT_W = 13;
    localparam int unsigned COUNT_W   = 12;
    localparam int unsigned WORD_W    = 32;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // carry out the captured operation
    } dp_cmd_t;

endpackage

// ===== rtl/iwls_ctrl.sv =====
// Controller state machine: accept, execute, respond
module iwls_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output iwls_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new beat may come in while the previous result is shown
    assign accept   = start && (state_reg != ST_EXEC);
    assign busy     = (state_reg == ST_EXEC);
    assign done     = (state_reg == ST_RESP);
    assign cmd.load = accept;
    assign cmd.exec = (state_reg == ST_EXEC);

    // Next state
    always_comb
    begin
        state_next = ST_IDLE;
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_RESP;
            ST_RESP: state_next = accept ? ST_EXEC : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/iwls_dp.sv =====
// Datapath: pointers, entry memories, result registers
module iwls_dp #(
    parameter int unsigned ENTRIES  = 4096,
    parameter int unsigned AUX_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  iwls_pkg::dp_cmd_t                    cmd,
    input  logic                                 cfg_we,
    input  logic                                 cfg_wdata,
    input  logic [2:0]                           func,
    input  logic [iwls_pkg::IDX_IN_W-1:0]        entry_index,
    input  logic [iwls_pkg::WORD_W-1:0]          state_value,
    input  logic [iwls_pkg::WORD_W-1:0]          parent_value,
    input  logic [iwls_pkg::WORD_W-1:0]          depth_value,
    input  logic [iwls_pkg::WORD_W-1:0]          aux_value,
    output logic [iwls_pkg::IDX_OUT_W-1:0]       index_out,
    output logic [iwls_pkg::WORD_W-1:0]          state_out,
    output logic [iwls_pkg::WORD_W-1:0]          parent_out,
    output logic [iwls_pkg::WORD_W-1:0]          depth_out,
    output logic [iwls_pkg::WORD_W-1:0]          aux_out,
    output logic [iwls_pkg::COUNT_W-1:0]         count_out,
    output logic [1:0]                           error_code
);

    localparam int unsigned WW    = iwls_pkg::WORD_W;
    localparam int unsigned PTR_W = $clog2(ENTRIES + 1);
    localparam int unsigned AW    = $clog2(ENTRIES);
    localparam int unsigned CMP_W = (PTR_W > iwls_pkg::IDX_OUT_W) ? PTR_W
                                                                  : iwls_pkg::IDX_OUT_W;
    localparam int unsigned AUX_W = (AUX_BITS < WW) ? AUX_BITS : WW;

    // Captured input beat
    logic [2:0]                   func_reg;
    logic [iwls_pkg::IDX_IN_W-1:0] idx_reg;
    logic [WW-1:0]                sv_reg;
    logic [WW-1:0]                pv_reg;
    logic [WW-1:0]                dv_reg;
    logic [AUX_W-1:0]             av_reg;

    // Control state
    logic [PTR_W-1:0] next_ptr_reg;
    logic [PTR_W-1:0] next_ptr_next;
    logic [PTR_W-1:0] front_ptr_reg;
    logic [PTR_W-1:0] front_ptr_next;
    logic             keep_depth_reg;

    // Result registers
    logic [iwls_pkg::IDX_OUT_W-1:0] res_index_reg;
    logic [iwls_pkg::IDX_OUT_W-1:0] res_index_next;
    logic [iwls_pkg::COUNT_W-1:0]   res_count_reg;
    logic [iwls_pkg::COUNT_W-1:0]   res_count_next;
    iwls_pkg::err_t                 res_err_reg;
    iwls_pkg::err_t                 res_err_next;
    logic                           res_rd_reg;
    logic                           res_rd_next;

    // Entry memories, one per field
    logic [WW-1:0]    state_mem  [ENTRIES];
    logic [WW-1:0]    parent_mem [ENTRIES];
    logic [WW-1:0]    depth_mem  [ENTRIES];
    logic [AUX_W-1:0] aux_mem    [ENTRIES];
    logic [WW-1:0]    state_rdata;
    logic [WW-1:0]    parent_rdata;
    logic [WW-1:0]    depth_rdata;
    logic [AUX_W-1:0] aux_rdata;

    // Decode helpers
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] next_ext;
    logic [CMP_W-1:0] next_dec_ext;
    logic [CMP_W-1:0] front_ext;
    logic [CMP_W-1:0] count_ext;
    logic [PTR_W-1:0] next_dec;
    logic             full;
    logic             empty;
    logic             idx_ok;
    logic             wr_insert;
    logic             wr_state;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [WW-1:0]    state_wdata;
    logic [WW-1:0]    depth_wdata;
    logic [WW-1:0]    aux_ext;

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            idx_reg  <= entry_index;
            sv_reg   <= state_value;
            pv_reg   <= parent_value;
            dv_reg   <= depth_value;
            av_reg   <= aux_value[AUX_W-1:0];
        end
    end

    // Pointer compares
    assign next_dec     = next_ptr_reg - PTR_W'(1);
    assign idx_ext      = CMP_W'(idx_reg);
    assign next_ext     = CMP_W'(next_ptr_reg);
    assign next_dec_ext = CMP_W'(next_dec);
    assign front_ext    = CMP_W'(front_ptr_reg);
    assign full         = (next_ptr_reg == PTR_W'(ENTRIES));
    assign empty        = (next_ptr_reg == front_ptr_reg);
    assign idx_ok       = (idx_reg != '0) && (idx_ext < next_ext);

    // Operation decode and pointer update
    always_comb
    begin
        next_ptr_next  = next_ptr_reg;
        front_ptr_next = front_ptr_reg;
        res_index_next = '0;
        res_err_next   = iwls_pkg::ERR_OK;
        res_rd_next    = 1'b0;
        wr_insert      = 1'b0;
        wr_state       = 1'b0;
        unique case (func_reg)
            iwls_pkg::FUNC_INSERT:
            begin
                if (full)
                begin
                    res_err_next = iwls_pkg::ERR_FULL;
                end
                else
                begin
                    wr_insert      = 1'b1;
                    res_index_next = next_ext[iwls_pkg::IDX_OUT_W-1:0];
                    next_ptr_next  = next_ptr_reg + PTR_W'(1);
                end
            end
            iwls_pkg::FUNC_POP_TOP:
            begin
                if (empty)
                begin
                    res_err_next = iwls_pkg::ERR_EMPTY;
                end
                else
                begin
                    next_ptr_next  = next_dec;
                    res_index_next = next_dec_ext[iwls_pkg::IDX_OUT_W-1:0];
                end
            end
            iwls_pkg::FUNC_POP_FRONT:
            begin
                if (empty)
                begin
                    res_err_next = iwls_pkg::ERR_EMPTY;
                end
                else
                begin
                    res_index_next = front_ext[iwls_pkg::IDX_OUT_W-1:0];
                    front_ptr_next = front_ptr_reg + PTR_W'(1);
                end
            end
            iwls_pkg::FUNC_READ:
            begin
                if (!idx_ok)
                begin
                    res_err_next = iwls_pkg::ERR_INDEX;
                end
                else
                begin
                    res_rd_next    = 1'b1;
                    res_index_next = idx_ext[iwls_pkg::IDX_OUT_W-1:0];
                end
            end
            iwls_pkg::FUNC_SET_STATE:
            begin
                if (!idx_ok)
                begin
                    res_err_next = iwls_pkg::ERR_INDEX;
                end
                else
                begin
                    wr_state       = 1'b1;
                    res_index_next = idx_ext[iwls_pkg::IDX_OUT_W-1:0];
                end
            end
            default:
            begin
                // status and unused codes report next
                res_index_next = next_ext[iwls_pkg::IDX_OUT_W-1:0];
            end
        endcase
    end

    // Count after the operation
    assign count_ext      = CMP_W'(next_ptr_next - front_ptr_next);
    assign res_count_next = count_ext[iwls_pkg::COUNT_W-1:0];

    // Memory addressing; an index that passed the check fits the address
    assign rd_addr     = idx_ext[AW-1:0];
    assign wr_addr     = wr_insert ? next_ext[AW-1:0] : idx_ext[AW-1:0];
    assign state_wdata = sv_reg;
    assign depth_wdata = keep_depth_reg ? dv_reg : '0;

    // State field: written by insert and set-state
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (wr_insert || wr_state))
        begin
            state_mem[wr_addr] <= state_wdata;
        end
        if (cmd.exec)
        begin
            state_rdata <= state_mem[rd_addr];
        end
    end

    // Parent, depth and aux fields: written by insert only
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_insert)
        begin
            parent_mem[wr_addr] <= pv_reg;
            depth_mem[wr_addr]  <= depth_wdata;
            aux_mem[wr_addr]    <= av_reg;
        end
        if (cmd.exec)
        begin
            parent_rdata <= parent_mem[rd_addr];
            depth_rdata  <= depth_mem[rd_addr];
            aux_rdata    <= aux_mem[rd_addr];
        end
    end

    // Pointers and depth-keep register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ptr_reg   <= PTR_W'(1);
            front_ptr_reg  <= PTR_W'(1);
            keep_depth_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                next_ptr_reg  <= next_ptr_next;
                front_ptr_reg <= front_ptr_next;
            end
            if (cfg_we)
            begin
                keep_depth_reg <= cfg_wdata;
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_index_reg <= res_index_next;
            res_count_reg <= res_count_next;
            res_err_reg   <= res_err_next;
            res_rd_reg    <= res_rd_next;
        end
    end

    // Result beat; entry fields are zero unless a read succeeded
    always_comb
    begin
        aux_ext             = '0;
        aux_ext[AUX_W-1:0]  = aux_rdata;
    end

    assign index_out  = res_index_reg;
    assign count_out  = res_count_reg;
    assign error_code = res_err_reg;
    assign state_out  = res_rd_reg ? state_rdata : '0;
    assign parent_out = res_rd_reg ? parent_rdata : '0;
    assign depth_out  = (res_rd_reg && keep_depth_reg) ? depth_rdata : '0;
    assign aux_out    = res_rd_reg ? aux_ext : '0;

endmodule

// ===== rtl/indexed_work_list_store_core.sv =====
// Top level of the indexed work-list store
//
// Command channel: an operation beat (func, entry_index and the value fields)
// is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with index_out, the
// entry fields, count_out and error_code valid; the receiver cannot stall,
// so a result is taken in the cycle it is shown.
// Sequence: the accepting edge moves the controller to the execute state,
// which holds the registered entry read and the pointer update, and from
// there to the response state, in which done is high and the result is shown.
// Overlap: busy is high only in the execute cycle, so the next beat may be
// taken while the previous result is shown.
// Configuration: cfg_we writes cfg_wdata into keep_depth; write only while
// no operation is in flight.
// Reset (rst_n low, asynchronous): front and next pointers go to 1, keep_depth
// to 0, the controller to idle. Entry contents are not cleared; an entry is
// only read after it was written, so no clearing pass is needed.
module indexed_work_list_store_core #(
    parameter int unsigned ENTRIES  = 4096,
    parameter int unsigned AUX_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    output logic                           done,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic [2:0]                     func,
    input  logic [iwls_pkg::IDX_IN_W-1:0]  entry_index,
    input  logic [iwls_pkg::WORD_W-1:0]    state_value,
    input  logic [iwls_pkg::WORD_W-1:0]    parent_value,
    input  logic [iwls_pkg::WORD_W-1:0]    depth_value,
    input  logic [iwls_pkg::WORD_W-1:0]    aux_value,
    output logic [iwls_pkg::IDX_OUT_W-1:0] index_out,
    output logic [iwls_pkg::WORD_W-1:0]    state_out,
    output logic [iwls_pkg::WORD_W-1:0]    parent_out,
    output logic [iwls_pkg::WORD_W-1:0]    depth_out,
    output logic [iwls_pkg::WORD_W-1:0]    aux_out,
    output logic [iwls_pkg::COUNT_W-1:0]   count_out,
    output logic [1:0]                     error_code
);

    iwls_pkg::dp_cmd_t cmd;

    // Sequencer
    iwls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Pointers, entries and results
    iwls_dp #(
        .ENTRIES  (ENTRIES),
        .AUX_BITS (AUX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .entry_index  (entry_index),
        .state_value  (state_value),
        .parent_value (parent_value),
        .depth_value  (depth_value),
        .aux_value    (aux_value),
        .index_out    (index_out),
        .state_out    (state_out),
        .parent_out   (parent_out),
        .depth_out    (depth_out),
        .aux_out      (aux_out),
        .count_out    (count_out),
        .error_code   (error_code)
    );

endmodule

// ===== rtl/iwls_checker.sv =====
// Port-level checker for the work-list store, bound to the top level
`include "indexed_work_list_store_core_macros.svh"

module iwls_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [iwls_pkg::IDX_OUT_W-1:0] index_out,
    input logic [iwls_pkg::WORD_W-1:0]    state_out,
    input logic [1:0]                     error_code
);

    // An accepted beat puts the block in its execute cycle
    `IWLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start execution")

    // Every execute cycle is followed by a result beat with busy low
    `IWLS_ASSERT_NEXT(a_exec_done, busy, done && !busy, "execute cycle without result beat")

    // A failed operation reports index zero
    `IWLS_ASSERT_NOW(a_err_index, done && (error_code != iwls_pkg::ERR_OK), index_out == '0, "error result with nonzero index")

    // A failed operation reads no entry
    `IWLS_ASSERT_NOW(a_err_state, done && (error_code != iwls_pkg::ERR_OK), state_out == '0, "error result with entry data")

endmodule

bind indexed_work_list_store_core iwls_checker u_iwls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .index_out  (index_out),
    .state_out  (state_out),
    .error_code (error_code)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the indexed work-list store core
`timescale 1ns / 1ps

module tb;

    localparam int unsigned WL_ENTRIES   = 4096;
    localparam int unsigned WL_AUX_BITS  = 32;
    // generous bound: ~1800 beats at worst-case gaps plus drains, many times over
    localparam int unsigned CYCLE_LIMIT  = 800_000;
    localparam int unsigned SEG_BEATS    = 250;
    localparam int unsigned SEG_COUNT    = 7;
    localparam int unsigned REPORT_MAX   = 10;

    // unused func codes, answered as status
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    // traffic mixes for the random segments
    localparam int MODE_GROW  = 0;
    localparam int MODE_MIX   = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        logic [iwls_pkg::IDX_OUT_W-1:0] idx;
        logic [iwls_pkg::WORD_W-1:0]    st;
        logic [iwls_pkg::WORD_W-1:0]    par;
        logic [iwls_pkg::WORD_W-1:0]    dep;
        logic [iwls_pkg::WORD_W-1:0]    aux;
        logic [iwls_pkg::COUNT_W-1:0]   cnt;
        iwls_pkg::err_t                 err;
    } wl_result_t;

    // Work-list predictor plus in-order result checker
    class wl_scoreboard;
        bit [iwls_pkg::WORD_W-1:0] state_mem  [WL_ENTRIES];
        bit [iwls_pkg::WORD_W-1:0] parent_mem [WL_ENTRIES];
        bit [iwls_pkg::WORD_W-1:0] depth_mem  [WL_ENTRIES];
        bit [iwls_pkg::WORD_W-1:0] aux_mem    [WL_ENTRIES];
        int unsigned     next_ptr;
        int unsigned     front_ptr;
        bit              keep_depth;
        wl_result_t      awaiting[$];
        int unsigned     fails;
        int unsigned     checked;
        int unsigned     op_tally  [8];
        int unsigned     err_tally [4];
        int unsigned     peak_live;

        function new();
            next_ptr   = 1;
            front_ptr  = 1;
            keep_depth = 1'b0;
            fails      = 0;
            checked    = 0;
            peak_live  = 0;
            foreach (op_tally[i]) op_tally[i] = 0;
            foreach (err_tally[i]) err_tally[i] = 0;
        endfunction

        function void set_keep_depth(bit v);
            keep_depth = v;
        endfunction

        function int unsigned pending();
            return awaiting.size();
        endfunction

        function bit index_ok(logic [iwls_pkg::IDX_IN_W-1:0] ix);
            return ix != 0 && ix < next_ptr;
        endfunction

        // predict the result of one accepted beat and advance the model
        function void apply_op(logic [2:0] f, logic [iwls_pkg::IDX_IN_W-1:0] ix,
                               logic [iwls_pkg::WORD_W-1:0] sv,
                               logic [iwls_pkg::WORD_W-1:0] pv,
                               logic [iwls_pkg::WORD_W-1:0] dv,
                               logic [iwls_pkg::WORD_W-1:0] av);
            wl_result_t r;
            r = '0;
            case (f)
                iwls_pkg::FUNC_INSERT:
                begin
                    if (next_ptr >= WL_ENTRIES)
                        r.err = iwls_pkg::ERR_FULL;
                    else
                    begin
                        state_mem[next_ptr]  = sv;
                        parent_mem[next_ptr] = pv;
                        depth_mem[next_ptr]  = keep_depth ? dv : '0;
                        aux_mem[next_ptr]    = av;   // AUX_BITS is the full word here
                        r.idx = iwls_pkg::IDX_OUT_W'(next_ptr);
                        next_ptr++;
                    end
                end
                iwls_pkg::FUNC_POP_TOP:
                begin
                    if (next_ptr == front_ptr)
                        r.err = iwls_pkg::ERR_EMPTY;
                    else
                    begin
                        next_ptr--;
                        r.idx = iwls_pkg::IDX_OUT_W'(next_ptr);
                    end
                end
                iwls_pkg::FUNC_POP_FRONT:
                begin
                    if (next_ptr == front_ptr)
                        r.err = iwls_pkg::ERR_EMPTY;
                    else
                    begin
                        r.idx = iwls_pkg::IDX_OUT_W'(front_ptr);
                        front_ptr++;
                    end
                end
                iwls_pkg::FUNC_READ:
                begin
                    if (!index_ok(ix))
                        r.err = iwls_pkg::ERR_INDEX;
                    else
                    begin
                        r.idx = iwls_pkg::IDX_OUT_W'(ix);
                        r.st  = state_mem[ix];
                        r.par = parent_mem[ix];
                        r.dep = keep_depth ? depth_mem[ix] : '0;
                        r.aux = aux_mem[ix];
                    end
                end
                iwls_pkg::FUNC_SET_STATE:
                begin
                    if (!index_ok(ix))
                        r.err = iwls_pkg::ERR_INDEX;
                    else
                    begin
                        state_mem[ix] = sv;
                        r.idx = iwls_pkg::IDX_OUT_W'(ix);
                    end
                end
                default: r.idx = iwls_pkg::IDX_OUT_W'(next_ptr);
            endcase
            r.cnt = iwls_pkg::COUNT_W'(next_ptr - front_ptr);
            op_tally[f]++;
            err_tally[r.err]++;
            if (next_ptr - front_ptr > peak_live)
                peak_live = next_ptr - front_ptr;
            awaiting.push_back(r);
        endfunction

        function void report(string why, wl_result_t want, wl_result_t got);
            fails++;
            if (fails <= REPORT_MAX)
            begin
                $display("%t %s", $realtime, why);
                $display("  expected idx=%0d st=%h par=%h dep=%h aux=%h cnt=%0d err=%0d",
                         want.idx, want.st, want.par, want.dep, want.aux, want.cnt, want.err);
                $display("  actual   idx=%0d st=%h par=%h dep=%h aux=%h cnt=%0d err=%0d",
                         got.idx, got.st, got.par, got.dep, got.aux, got.cnt, got.err);
            end
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(wl_result_t got);
            wl_result_t want;
            if (awaiting.size() == 0)
            begin
                report("result beat with nothing outstanding", '0, got);
                return;
            end
            want = awaiting.pop_front();
            checked++;
            if (got !== want)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           done;
    logic                           cfg_we;
    logic                           cfg_wdata;
    logic [2:0]                     func;
    logic [iwls_pkg::IDX_IN_W-1:0]  entry_index;
    logic [iwls_pkg::WORD_W-1:0]    state_value;
    logic [iwls_pkg::WORD_W-1:0]    parent_value;
    logic [iwls_pkg::WORD_W-1:0]    depth_value;
    logic [iwls_pkg::WORD_W-1:0]    aux_value;
    logic [iwls_pkg::IDX_OUT_W-1:0] index_out;
    logic [iwls_pkg::WORD_W-1:0]    state_out;
    logic [iwls_pkg::WORD_W-1:0]    parent_out;
    logic [iwls_pkg::WORD_W-1:0]    depth_out;
    logic [iwls_pkg::WORD_W-1:0]    aux_out;
    logic [iwls_pkg::COUNT_W-1:0]   count_out;
    logic [1:0]                     error_code;

    wl_scoreboard sb;
    int unsigned  cycle_count = 0;

    indexed_work_list_store_core #(
        .ENTRIES  (WL_ENTRIES),
        .AUX_BITS (WL_AUX_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .entry_index  (entry_index),
        .state_value  (state_value),
        .parent_value (parent_value),
        .depth_value  (depth_value),
        .aux_value    (aux_value),
        .index_out    (index_out),
        .state_out    (state_out),
        .parent_out   (parent_out),
        .depth_out    (depth_out),
        .aux_out      (aux_out),
        .count_out    (count_out),
        .error_code   (error_code)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("** indexed_work_list_store_core: FAILED **");
            $finish;
        end
    end

    // result beats are taken at the edge that ends their cycle
    always @(posedge clk)
    begin
        wl_result_t got;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            got.idx = index_out;
            got.st  = state_out;
            got.par = parent_out;
            got.dep = depth_out;
            got.aux = aux_out;
            got.cnt = count_out;
            got.err = iwls_pkg::err_t'(error_code);
            sb.check_result(got);
        end
    end

    // present one command beat and hold it until taken; start stays high
    task automatic send_op(input logic [2:0] f, input logic [iwls_pkg::IDX_IN_W-1:0] ix,
                           input logic [iwls_pkg::WORD_W-1:0] sv,
                           input logic [iwls_pkg::WORD_W-1:0] pv,
                           input logic [iwls_pkg::WORD_W-1:0] dv,
                           input logic [iwls_pkg::WORD_W-1:0] av);
        func         <= f;
        entry_index  <= ix;
        state_value  <= sv;
        parent_value <= pv;
        depth_value  <= dv;
        aux_value    <= av;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.apply_op(f, ix, sv, pv, dv, av);
    endtask

    task automatic idle_for(input int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // hold off the command side until every predicted result is back
    task automatic wait_results_out();
        if (sb.pending() != 0)
        begin
            start <= 1'b0;
            while (sb.pending() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_keep_depth(input bit v);
        wait_results_out();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_keep_depth(v);
    endtask

    function automatic logic [iwls_pkg::WORD_W-1:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // mostly live entries, with the newest one favored
    function automatic logic [iwls_pkg::IDX_IN_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.next_ptr > 1 && r < 30)
            return iwls_pkg::IDX_IN_W'(sb.next_ptr - 1);
        if (sb.next_ptr > 1 && r < 80)
            return iwls_pkg::IDX_IN_W'($urandom_range(1, sb.next_ptr - 1));
        if (r < 88)
            return iwls_pkg::IDX_IN_W'($urandom);
        if (r < 92)
            return '0;
        if (r < 96)
            return iwls_pkg::IDX_IN_W'(sb.next_ptr);
        return '1;
    endfunction

    function automatic logic [2:0] pick_func(input int mode);
        int unsigned r;
        int unsigned ins;
        int unsigned pops;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:  begin ins = 45; pops = 8;  end
            MODE_DRAIN: begin ins = 15; pops = 25; end
            default:    begin ins = 30; pops = 15; end
        endcase
        if (r < ins)
            return iwls_pkg::FUNC_INSERT;
        if (r < ins + pops)
            return iwls_pkg::FUNC_POP_TOP;
        if (r < ins + 2 * pops)
            return iwls_pkg::FUNC_POP_FRONT;
        r = $urandom_range(0, 19);
        if (r < 11)
            return iwls_pkg::FUNC_READ;
        if (r < 16)
            return iwls_pkg::FUNC_SET_STATE;
        if (r < 18)
            return iwls_pkg::FUNC_STATUS;
        return (r == 18) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    task automatic run_segment(input int unsigned beats, input int mode, input bit burst);
        repeat (beats)
        begin
            send_op(pick_func(mode), pick_index(), rand_word(), rand_word(),
                    rand_word(), rand_word());
            idle_for(burst ? 0 : pick_gap());
        end
    endtask

    initial
    begin
        int modes [SEG_COUNT];
        sb = new();
        modes = '{MODE_GROW, MODE_MIX, MODE_DRAIN, MODE_MIX, MODE_MIX, MODE_DRAIN,
                  MODE_GROW};
        rst_n        <= 1'b0;
        start        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= 1'b0;
        func         <= iwls_pkg::FUNC_STATUS;
        entry_index  <= '0;
        state_value  <= '0;
        parent_value <= '0;
        depth_value  <= '0;
        aux_value    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, bad indices, spare codes, extremes, queue/stack order
        send_op(iwls_pkg::FUNC_POP_TOP, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_FRONT, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd1, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_SET_STATE, '1, '1, '0, '0, '0);
        send_op(iwls_pkg::FUNC_STATUS, '1, '1, '1, '1, '1);
        send_op(FUNC_SPARE_6, '0, '0, '0, '0, '0);
        send_op(FUNC_SPARE_7, '1, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_INSERT, '1, '1, '1, '1, '1);
        send_op(iwls_pkg::FUNC_INSERT, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_INSERT, 12'hAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555);
        send_op(iwls_pkg::FUNC_READ, 12'd1, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd2, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd3, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_SET_STATE, 12'd2, '1, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd2, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd4, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_FRONT, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd1, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_TOP, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_READ, 12'd3, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_FRONT, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_FRONT, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_POP_TOP, '0, '0, '0, '0, '0);
        send_op(iwls_pkg::FUNC_STATUS, '0, '0, '0, '0, '0);

        // random segments, keep_depth changed between them
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            case (s % 3)
                0:       write_keep_depth(1'b1);
                1:       write_keep_depth(1'b0);
                default: write_keep_depth(1'($urandom_range(0, 1)));
            endcase
            run_segment(SEG_BEATS, modes[s], $urandom_range(0, 3) == 0);
        end

        // let the last results land, then allow a few quiet cycles for strays
        wait_results_out();
        repeat (8) @(posedge clk);

        $display("beats: %0d insert, %0d pop-top, %0d pop-front, %0d read, %0d set",
                 sb.op_tally[iwls_pkg::FUNC_INSERT], sb.op_tally[iwls_pkg::FUNC_POP_TOP],
                 sb.op_tally[iwls_pkg::FUNC_POP_FRONT], sb.op_tally[iwls_pkg::FUNC_READ],
                 sb.op_tally[iwls_pkg::FUNC_SET_STATE]);
        $display("%0d status; %0d results checked; errors empty %0d, full %0d, bad index %0d",
                 sb.op_tally[iwls_pkg::FUNC_STATUS] + sb.op_tally[FUNC_SPARE_6]
                     + sb.op_tally[FUNC_SPARE_7],
                 sb.checked, sb.err_tally[iwls_pkg::ERR_EMPTY],
                 sb.err_tally[iwls_pkg::ERR_FULL], sb.err_tally[iwls_pkg::ERR_INDEX]);
        if (sb.fails == 0)
            $display("** indexed_work_list_store_core: PASSED **");
        else
            $display("** indexed_work_list_store_core: FAILED **");
        $finish;
    end

endmodule
